// ----- rtl/core/flow_blocklist_filter_unit_defines.svh -----
//------------------------------------------------------------------------------
// flow_blocklist_filter_unit_defines.svh
// Assertion macros shared by the blocklist filter RTL.
//------------------------------------------------------------------------------
`ifndef FLOW_BLOCKLIST_FILTER_UNIT_DEFINES_SVH
`define FLOW_BLOCKLIST_FILTER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FBF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define FBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fbf_pkg.sv -----
//------------------------------------------------------------------------------
// fbf_pkg
// Types and sizes shared by the blocklist filter and its cells.
//------------------------------------------------------------------------------
`default_nettype none

package fbf_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int QP_W    = 24;
    localparam int ADDR_W  = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [QP_W-1:0]   qp_number;
        logic [ADDR_W-1:0] dst_addr;
    } t_item;

    typedef struct packed {
        logic             drop;
        logic             inserted;
        logic [CNT_W-1:0] stored_count;
    } t_result;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic act;
        logic qp_hit;
        logic pair_hit;
    } t_link;

    // Key broadcast to every cell.
    typedef struct packed {
        logic [QP_W-1:0]   qp;
        logic [ADDR_W-1:0] addr;
    } t_key;

endpackage

`default_nettype wire

// ----- rtl/core/flow_blocklist_filter_unit.sv -----
//------------------------------------------------------------------------------
// flow_blocklist_filter_unit
// Blocklist of (queue pair, destination address) pairs with insert and lookup.
//------------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A search token then
// walks the row of ENTRIES cells, one cell per clock, and busy stays high
// until the token leaves the last cell; the result is registered there and
// the result strobe o_done is shown for a single cycle. Only one item is in
// the walk at a time, and the next may be started in the cycle the strobe
// is shown. The receiver cannot stall: o_result is valid only
// while o_done is high. A lookup sets drop when its queue pair number matches
// any stored entry. An insert stores its pair in the next free slot unless
// the exact pair is already present; once the list is full the last slot is
// overwritten. stored_count reports the number of valid entries after the
// item. Slots at or above the count are never compared, so the stores need
// no clearing after reset.
//------------------------------------------------------------------------------
`default_nettype none

`include "flow_blocklist_filter_unit_defines.svh"

module flow_blocklist_filter_unit
    import fbf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_done,
    output t_result    o_result
);

    // Control state
    logic             r_busy;
    logic             n_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             n_done;

    // Item held while the token travels
    logic             r_op;
    t_key             r_key;
    t_key             w_key;
    t_result          r_result;
    t_result          n_result;

    // Token chain: entry 0 is the injection point, entry ENTRIES the tail
    t_link            w_link [0:ENTRIES];

    logic             accept;
    logic             finish;
    logic             full;
    logic             wr_en;
    logic [SLOT_W-1:0] wr_slot;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // The first cell compares in the transfer cycle, before r_key is loaded,
    // so show it the incoming key directly.
    assign w_key = accept ? t_key'{i_item.qp_number, i_item.dst_addr} : r_key;

    // Inject the token together with the accepted item.
    always_comb begin
        w_link[0].act      = accept;
        w_link[0].qp_hit   = 1'b0;
        w_link[0].pair_hit = 1'b0;
    end

    // The token leaving the last cell carries the full search result.
    assign finish  = w_link[ENTRIES].act;
    assign full    = r_count == CNT_W'(ENTRIES);
    assign wr_en   = finish && (r_op == OP_INSERT) && !w_link[ENTRIES].pair_hit;
    assign wr_slot = full ? SLOT_W'(ENTRIES - 1) : r_count[SLOT_W-1:0];

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            fbf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (w_key),
                .i_link  (w_link[k]),
                .i_live  (CNT_W'(k) < r_count),
                .i_wr    (wr_en && (wr_slot == SLOT_W'(k))),
                .o_link  (w_link[k+1])
            );
        end
    endgenerate

    // Advance the count on a new pair unless the list is already full.
    always_comb begin
        n_count = r_count;
        if (wr_en && !full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Hold busy from accept until the token leaves the tail.
    always_comb begin
        n_busy = r_busy;
        priority if (accept) begin
            n_busy = 1'b1;
        end else if (finish) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_done                = finish;
        n_result.drop         = (r_op == OP_LOOKUP) && w_link[ENTRIES].qp_hit;
        n_result.inserted     = wr_en;
        n_result.stored_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Capture the item on accept; register the result at the tail.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_item.opcode;
            r_key.qp   <= i_item.qp_number;
            r_key.addr <= i_item.dst_addr;
        end
        if (finish) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Checks
    `FBF_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(ENTRIES), "count above capacity")
    `FBF_ASSERT_NEXT(a_accept_busy, accept, r_busy, "busy not raised after transfer")
    `FBF_ASSERT_SAME(a_done_idle, o_done, !r_busy, "result strobe while busy")
    `FBF_ASSERT_SAME(a_drop_excl, o_done, !(o_result.drop && o_result.inserted), "drop with insert")
    `FBF_ASSERT_NEXT(a_count_step, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)), "count jumped")

endmodule

`default_nettype wire

// ----- rtl/core/fbf_cell.sv -----
//------------------------------------------------------------------------------
// fbf_cell
// One blocklist slot: stores a pair, compares it against the key and passes
// the accumulated match flags on to the next cell.
//------------------------------------------------------------------------------
`default_nettype none

module fbf_cell
    import fbf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_key  i_key,
    input  wire t_link i_link,
    input  wire logic  i_live,
    input  wire logic  i_wr,
    output t_link      o_link
);

    logic [QP_W-1:0]   r_qp;
    logic [ADDR_W-1:0] r_addr;
    t_link             r_link;
    t_link             n_link;
    logic              qp_eq;
    logic              addr_eq;

    assign qp_eq   = i_live && (r_qp == i_key.qp);
    assign addr_eq = r_addr == i_key.addr;

    always_comb begin
        n_link.act      = i_link.act;
        n_link.qp_hit   = i_link.qp_hit | (i_link.act & qp_eq);
        n_link.pair_hit = i_link.pair_hit | (i_link.act & qp_eq & addr_eq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_qp   <= i_key.qp;
            r_addr <= i_key.addr;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ----- tb/sv/flow_blocklist_filter_checker.sv -----
//------------------------------------------------------------------------------
// flow_blocklist_filter_checker
// Tracks the blocklist contents and scores every result strobe.
//------------------------------------------------------------------------------
// Samples both channels at the rising edge. Each accepted item is applied to
// a private copy of the list, and the result it should give is queued. Each
// strobe is compared field by field with the oldest queued result.
//------------------------------------------------------------------------------
module flow_blocklist_filter_checker
    import fbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [QP_W-1:0]   qp_store   [ENTRIES];
    logic [ADDR_W-1:0] addr_store [ENTRIES];
    logic [CNT_W-1:0]  fill;

    t_result expected_q [$];
    int      fail_cnt;
    int      checked_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fail_cnt     = 0;
        checked_cnt  = 0;
        fill         = '0;
    end

    // Apply one item to the list copy and return the result it gives.
    function automatic t_result blocklist_apply(input t_item it);
        t_result r;
        logic    qp_hit;
        logic    pair_hit;
        int      slot;
        r        = '0;
        qp_hit   = 1'b0;
        pair_hit = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (k < fill) begin
                if (qp_store[k] == it.qp_number) begin
                    qp_hit = 1'b1;
                    if (addr_store[k] == it.dst_addr)
                        pair_hit = 1'b1;
                end
            end
        end
        if (it.opcode == OP_INSERT) begin
            if (!pair_hit) begin
                if (fill < ENTRIES) begin
                    slot = fill;
                    fill = fill + 1'b1;
                end else begin
                    slot = ENTRIES - 1;
                end
                qp_store[slot]   = it.qp_number;
                addr_store[slot] = it.dst_addr;
                r.inserted       = 1'b1;
            end
        end else begin
            r.drop = qp_hit;
        end
        r.stored_count = fill;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            fill = '0;
            expected_q.delete();
        end else begin
            // Score the strobe against the oldest outstanding transfer first.
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    $error("result strobe with no transfer outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    checked_cnt++;
                    if (i_result.drop !== want.drop) begin
                        $error("drop: expected %0d, actual %0d", want.drop, i_result.drop);
                        fail_cnt++;
                    end
                    if (i_result.inserted !== want.inserted) begin
                        $error("inserted: expected %0d, actual %0d",
                               want.inserted, i_result.inserted);
                        fail_cnt++;
                    end
                    if (i_result.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, actual %0d",
                               want.stored_count, i_result.stored_count);
                        fail_cnt++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_q.push_back(blocklist_apply(i_item));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_q.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ----- tb/sv/tb.sv -----
//------------------------------------------------------------------------------
// tb
// Stimulus and verdict for the blocklist filter unit.
//------------------------------------------------------------------------------
// Runs a directed pass over the empty list, duplicates, a fill to capacity
// and an overwrite of the last slot, then a long random pass drawn mostly from
// small pools of queue pairs and addresses so that hits, duplicates and
// overwrites keep happening, with start gaps of random length.
// Scoring is done by the checker instance.
//------------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbf_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1075;
    localparam int LATENCY      = ENTRIES + 1;
    localparam int QP_POOL      = 6;
    localparam int ADDR_POOL    = 4;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_done;
    t_result o_result;

    int fail_count;
    int pending_count;
    int checked_count;
    int n_insert;
    int n_lookup;

    logic [QP_W-1:0]   qp_pool   [QP_POOL];
    logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
    t_item             directed_q [$];

    always #6 i_clk = ~i_clk;

    flow_blocklist_filter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    flow_blocklist_filter_checker u_blocklist_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    function automatic t_item mk(input logic op, input logic [QP_W-1:0] qp,
                                 input logic [ADDR_W-1:0] addr);
        t_item it;
        it.opcode    = op;
        it.qp_number = qp;
        it.dst_addr  = addr;
        return it;
    endfunction

    // Mostly pool draws so that lookups hit and inserts repeat; the rest is
    // noise over the full field ranges.
    function automatic t_item random_item();
        t_item it;
        it.opcode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 75) begin
            it.qp_number = qp_pool[$urandom_range(0, QP_POOL - 1)];
            it.dst_addr  = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
        end else begin
            it.qp_number = QP_W'($urandom);
            it.dst_addr  = ADDR_W'($urandom);
        end
        return it;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Present one item after an idle gap and hold it until the transfer.
    task automatic send_item(input t_item it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        if (it.opcode == OP_INSERT)
            n_insert++;
        else
            n_lookup++;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_item   <= '0;
        n_insert = 0;
        n_lookup = 0;

        // Seed the pools; pin the extremes so they recur in the random pass.
        foreach (qp_pool[k])
            qp_pool[k] = QP_W'($urandom);
        foreach (addr_pool[k])
            addr_pool[k] = ADDR_W'($urandom);
        qp_pool[0]   = '0;
        qp_pool[1]   = '1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        // Empty list: lookups never drop, whatever the address.
        directed_q.push_back(mk(OP_LOOKUP, 24'h000000, 32'h00000000));
        directed_q.push_back(mk(OP_LOOKUP, 24'hFFFFFF, 32'hFFFFFFFF));
        // First insert, then the same pair again as a duplicate.
        directed_q.push_back(mk(OP_INSERT, 24'h000000, 32'h00000000));
        directed_q.push_back(mk(OP_INSERT, 24'h000000, 32'h00000000));
        // Same queue pair with another address is a new pair.
        directed_q.push_back(mk(OP_INSERT, 24'h000000, 32'hFFFFFFFF));
        directed_q.push_back(mk(OP_INSERT, 24'hFFFFFF, 32'h00000000));
        // Lookups ignore the address: hit, hit, miss.
        directed_q.push_back(mk(OP_LOOKUP, 24'h000000, 32'h5A5A5A5A));
        directed_q.push_back(mk(OP_LOOKUP, 24'hFFFFFF, 32'hFFFFFFFF));
        directed_q.push_back(mk(OP_LOOKUP, 24'h000001, 32'h00000000));
        // Fill the list to capacity.
        for (int k = 0; k < ENTRIES - 3; k++)
            directed_q.push_back(mk(OP_INSERT, QP_W'(24'h000100 + k), ADDR_W'(k)));
        // Full list: overwrite the last slot, then probe old and new owners.
        directed_q.push_back(mk(OP_INSERT, 24'hABCDEF, 32'h12345678));
        directed_q.push_back(mk(OP_LOOKUP, QP_W'(24'h000100 + ENTRIES - 4), 32'h0));
        directed_q.push_back(mk(OP_LOOKUP, 24'hABCDEF, 32'h0));
        directed_q.push_back(mk(OP_INSERT, 24'hABCDEF, 32'h12345678));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[k])
            send_item(directed_q[k], random_gap());

        // Every fifth block of twenty items runs with no idling at all.
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_item(), ((n % 100) < 20) ? 0 : random_gap());

        // Drop start and drain; let the pipeline settle before the verdict.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Covered %0d transfers (%0d inserts, %0d lookups), %0d results scored,",
                 n_insert + n_lookup, n_insert, n_lookup, checked_count);
        $display("from the empty list through fill-up and last-slot overwrites.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- flow_blocklist_filter_unit.f -----
+incdir+rtl/core
rtl/core/fbf_pkg.sv
rtl/core/fbf_cell.sv
rtl/core/flow_blocklist_filter_unit.sv
tb/sv/flow_blocklist_filter_checker.sv
tb/sv/tb.sv
